[rtl/dq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants of the double-ended queue: request codes,
// status codes, controller states and the command and status groups
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

    // field widths of the request and result transfers
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // default number of stored words
    localparam int DQ_DEPTH = 16;

    // data word of a result that carries an error, and of an unused code
    localparam logic [VALUE_W-1:0] DATA_ERR  = '1;
    localparam logic [VALUE_W-1:0] DATA_NONE = '0;

    // request codes
    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 3'd0,
        K_POP_FRONT  = 3'd1,
        K_POP_BACK   = 3'd2,
        K_READ_FIRST = 3'd3,
        K_READ_LAST  = 3'd4,
        K_READ_AT    = 3'd5
    } t_kind;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;   // request transfer this cycle
        logic capture;  // memory read data is valid this cycle
    } t_dq_cmd;

    // datapath to controller
    typedef struct packed {
        logic needs_read; // current request reads the memory
    } t_dq_sts;

endpackage : dq_pkg
`default_nettype wire

[rtl/dq_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dq_req_if / dq_rsp_if
// Valid/ready channels carrying requests into and results out of the
// double-ended queue.
// ----------------------------------------------------------------------------
interface dq_req_if;
    import dq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;

    modport source (output valid, output kind, output value, output position,
                    input ready);
    modport sink   (input valid, input kind, input value, input position,
                    output ready);
endinterface : dq_req_if

interface dq_rsp_if;
    import dq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] data;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        count;

    modport source (output valid, output data, output status, output count,
                    input ready);
    modport sink   (input valid, input data, input status, input count,
                    output ready);
endinterface : dq_rsp_if
`default_nettype wire

[rtl/dq_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule : dq_ram
`default_nettype wire

[rtl/dq_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer of the double-ended queue: takes one request, waits for the
// memory read where one is needed, then holds the result until transfer.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire dq_pkg::t_dq_sts i_sts,
    output dq_pkg::t_dq_cmd      o_cmd
);
    import dq_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.needs_read ? S_READ : S_DONE;
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        o_out_valid   = (r_state == S_DONE);
        o_cmd.accept  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.capture = (r_state == S_READ);
    end

    // a read request waits in the read state for the memory
    a_read_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_sts.needs_read) |=> (r_state == S_READ))
        else $error("read request did not wait for memory");

    // other requests go straight to the result state without a memory read
    a_direct_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && !i_sts.needs_read) |=> o_out_valid)
        else $error("direct result not presented");

    // captured read data is presented next cycle
    a_capture_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (o_out_valid && !o_in_ready))
        else $error("read result not presented");

endmodule : dq_ctrl
`default_nettype wire

[rtl/dq_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dq_datapath
// Ring pointers, entry count, word store and result register of the
// double-ended queue.
// ----------------------------------------------------------------------------
module dq_datapath #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire dq_pkg::t_dq_cmd                   i_cmd,
    output dq_pkg::t_dq_sts                        o_sts,
    input  wire logic [dq_pkg::KIND_W-1:0]         i_kind,
    input  wire logic signed [dq_pkg::VALUE_W-1:0] i_value,
    input  wire logic [dq_pkg::POS_W-1:0]          i_position,
    output logic signed [dq_pkg::VALUE_W-1:0]      o_data,
    output logic [dq_pkg::STATUS_W-1:0]            o_status,
    output logic [dq_pkg::COUNT_W-1:0]             o_count
);
    import dq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [PTR_W:0]   SLOT_LIM = (PTR_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [PTR_W-1:0]   r_front;
    logic [PTR_W-1:0]   n_front;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [VALUE_W-1:0] r_data;
    logic [VALUE_W-1:0] n_data;
    t_status            r_status;
    t_status            n_status;

    logic               is_empty;
    logic               is_full;
    logic [PTR_W-1:0]   front_dec;
    logic [PTR_W-1:0]   front_inc;
    logic [PTR_W-1:0]   back_slot;
    logic [PTR_W-1:0]   pos_slot;
    logic [CNT_W-1:0]   cnt_m1;
    logic               pos_over;

    logic               ram_we;
    logic [PTR_W-1:0]   ram_addr;
    logic [VALUE_W-1:0] ram_rdata;
    logic               needs_read;

    // ring slot at an offset below the depth from a base slot
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W:0]   off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + off;
        if (sum >= SLOT_LIM) begin
            sum = sum - SLOT_LIM;
        end
        return sum[PTR_W-1:0];
    endfunction

    // ring positions and occupancy
    always_comb begin
        is_empty  = (r_count == '0);
        is_full   = (r_count == CNT_FULL);
        cnt_m1    = r_count - 1'b1;
        front_dec = (r_front == '0) ? PTR_LAST : r_front - 1'b1;
        front_inc = slot_of(r_front, (PTR_W + 1)'(1));
        back_slot = slot_of(r_front, (PTR_W + 1)'(cnt_m1));
        pos_slot  = slot_of(r_front, (PTR_W + 1)'(i_position));
        pos_over  = (CMP_W'(i_position) >= CMP_W'(r_count));
    end

    // request decode
    always_comb begin
        n_front    = r_front;
        n_count    = r_count;
        n_data     = DATA_ERR;
        n_status   = ST_OK;
        ram_we     = 1'b0;
        ram_addr   = r_front;
        needs_read = 1'b0;
        unique case (i_kind) inside
            K_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    ram_we   = i_cmd.accept;
                    ram_addr = front_dec;
                    n_front  = front_dec;
                    n_count  = r_count + 1'b1;
                    n_data   = i_value;
                end
            end
            K_POP_FRONT, K_READ_FIRST: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    needs_read = 1'b1;
                    if (i_kind == K_POP_FRONT) begin
                        n_front = front_inc;
                        n_count = cnt_m1;
                    end
                end
            end
            K_POP_BACK, K_READ_LAST: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    needs_read = 1'b1;
                    ram_addr   = back_slot;
                    if (i_kind == K_POP_BACK) begin
                        n_count = cnt_m1;
                    end
                end
            end
            K_READ_AT: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else if (pos_over) begin
                    n_status = ST_RANGE;
                end else begin
                    needs_read = 1'b1;
                    ram_addr   = pos_slot;
                end
            end
            default: begin
                n_data = DATA_NONE;
            end
        endcase
    end

    assign o_sts.needs_read = needs_read;

    // pointer and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.accept) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // result register, loaded at request or from the memory read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_data   <= n_data;
            r_status <= n_status;
        end else if (i_cmd.capture) begin
            r_data <= ram_rdata;
        end
    end

    // word store
    dq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_value),
        .o_rdata (ram_rdata)
    );

    assign o_data   = r_data;
    assign o_status = r_status;
    assign o_count  = COUNT_W'(r_count);

    // occupancy never exceeds the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("entry count beyond depth");

    // front pointer stays on the ring
    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_front} < SLOT_LIM)
        else $error("front pointer off the ring");

    // a pop on a non-empty queue removes exactly one entry
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && !is_empty &&
         (i_kind == K_POP_FRONT || i_kind == K_POP_BACK))
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not remove one entry");

endmodule : dq_datapath
`default_nettype wire

[rtl/double_ended_queue.sv]
`default_nettype none
// Results: a push, an error or an unused code has its result valid the cycle
//   after the request transfer; a pop or read first passes through the read
//   state (registered read of the single-port word store).
// Requests: one at a time; a new one is taken only once the result transfers.
// Reset clears the front pointer and the entry count; stored words are not
//   cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed words held in a ring buffer.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dq_req_if.sink    i_req,
    dq_rsp_if.source  o_rsp
);
    import dq_pkg::*;

    t_dq_cmd dq_cmd;
    t_dq_sts dq_sts;

    // request sequencing
    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (dq_sts),
        .o_cmd       (dq_cmd)
    );

    // storage and result
    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dq_cmd),
        .o_sts      (dq_sts),
        .i_kind     (i_req.kind),
        .i_value    (i_req.value),
        .i_position (i_req.position),
        .o_data     (o_rsp.data),
        .o_status   (o_rsp.status),
        .o_count    (o_rsp.count)
    );

endmodule : double_ended_queue
`default_nettype wire

[test/tb_double_ended_queue.sv]
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the ring-buffer double-ended queue. A short table of
// directed requests covers the empty, full and out-of-range cases and the
// field extremes. Bursts of random requests, biased to fill, drain or mix,
// follow under three patterns of idling on both channels. Each result is
// compared with its expected table entry if any, else a behavioural copy.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
    import dq_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 5;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 115;
    localparam int SETTLE_LEN  = 8;

    // request codes the block must ignore
    localparam logic [KIND_W-1:0] K_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] K_SPARE_7 = 3'd7;

    localparam logic signed [VALUE_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN  = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_ZERO = 32'sh0000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_PAT  = 32'sh5A5A_5A5A;
    localparam logic [POS_W-1:0]          POS_TOP  = 4'd15;

    typedef struct packed {
        logic signed [VALUE_W-1:0] data;
        t_status                   status;
        logic [COUNT_W-1:0]        count;
    } deque_result_t;

    // one directed row; rows with several repeats push random words
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
        logic [7:0]                reps;
        logic                      typed;
        deque_result_t             result;
    } dir_row_t;

    localparam int N_DIR = 25;
    localparam dir_row_t DIRECTED_ROWS [0:N_DIR-1] = '{
        // empty queue after reset
        '{K_POP_FRONT,  VAL_ZERO, 4'd0,    8'd1,  1'b1, '{DATA_ERR, ST_EMPTY, 5'd0}},
        '{K_POP_BACK,   VAL_ZERO, 4'd0,    8'd1,  1'b1, '{DATA_ERR, ST_EMPTY, 5'd0}},
        '{K_READ_FIRST, VAL_ZERO, 4'd0,    8'd1,  1'b1, '{DATA_ERR, ST_EMPTY, 5'd0}},
        '{K_READ_LAST,  VAL_ZERO, 4'd0,    8'd1,  1'b1, '{DATA_ERR, ST_EMPTY, 5'd0}},
        '{K_READ_AT,    VAL_ZERO, POS_TOP, 8'd1,  1'b1, '{DATA_ERR, ST_EMPTY, 5'd0}},
        '{K_SPARE_6,    VAL_MAX,  POS_TOP, 8'd1,  1'b1, '{DATA_NONE, ST_OK, 5'd0}},
        '{K_SPARE_7,    VAL_MIN,  4'd0,    8'd1,  1'b1, '{DATA_NONE, ST_OK, 5'd0}},
        // pushes of the extreme words
        '{K_PUSH_FRONT, VAL_MAX,  4'd0,    8'd1,  1'b1, '{VAL_MAX,  ST_OK, 5'd1}},
        '{K_PUSH_FRONT, VAL_MIN,  4'd0,    8'd1,  1'b1, '{VAL_MIN,  ST_OK, 5'd2}},
        '{K_PUSH_FRONT, DATA_ERR, 4'd0,    8'd1,  1'b1, '{DATA_ERR, ST_OK, 5'd3}},
        '{K_PUSH_FRONT, VAL_ZERO, 4'd0,    8'd1,  1'b1, '{VAL_ZERO, ST_OK, 5'd4}},
        // reads of the four entries, in and out of range, then pops at both ends
        '{K_READ_FIRST, VAL_ZERO, 4'd0,    8'd1,  1'b1, '{VAL_ZERO, ST_OK, 5'd4}},
        '{K_READ_LAST,  VAL_ZERO, 4'd0,    8'd1,  1'b1, '{VAL_MAX,  ST_OK, 5'd4}},
        '{K_READ_AT,    VAL_ZERO, 4'd3,    8'd1,  1'b1, '{VAL_MAX,  ST_OK, 5'd4}},
        '{K_READ_AT,    VAL_ZERO, 4'd4,    8'd1,  1'b1, '{DATA_ERR, ST_RANGE, 5'd4}},
        '{K_READ_AT,    VAL_ZERO, POS_TOP, 8'd1,  1'b1, '{DATA_ERR, ST_RANGE, 5'd4}},
        '{K_READ_AT,    VAL_ZERO, 4'd1,    8'd1,  1'b1, '{DATA_ERR, ST_OK, 5'd4}},
        '{K_POP_BACK,   VAL_ZERO, 4'd0,    8'd1,  1'b1, '{VAL_MAX,  ST_OK, 5'd3}},
        '{K_POP_FRONT,  VAL_ZERO, 4'd0,    8'd1,  1'b1, '{VAL_ZERO, ST_OK, 5'd2}},
        // fill to the brim, overflow, then read and pop
        '{K_PUSH_FRONT, VAL_ZERO, 4'd0,    8'd14, 1'b0, '0},
        '{K_PUSH_FRONT, VAL_PAT,  4'd0,    8'd1,  1'b1, '{DATA_ERR, ST_FULL, 5'd16}},
        '{K_READ_AT,    VAL_ZERO, POS_TOP, 8'd1,  1'b0, '0},
        '{K_POP_BACK,   VAL_ZERO, 4'd0,    8'd1,  1'b1, '{VAL_MIN,  ST_OK, 5'd15}},
        '{K_POP_FRONT,  VAL_ZERO, 4'd0,    8'd1,  1'b0, '0},
        '{K_READ_LAST,  VAL_ZERO, 4'd0,    8'd1,  1'b1, '{DATA_ERR, ST_OK, 5'd14}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    dq_req_if req_ch ();
    dq_rsp_if rsp_ch ();

    double_ended_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // behavioural copy of the queue
    logic signed [VALUE_W-1:0] model_ring [DQ_DEPTH];
    int                        model_head;
    int                        model_fill;

    deque_result_t pending_results [$];

    int source_idle_pct;
    int sink_idle_pct;
    int n_requests;
    int n_results;
    int n_errors;
    int status_seen [4];
    int peak_fill;
    int quiet_cycles;

    always #CLK_HALF i_clk = ~i_clk;

    // expected result of one request, updating the queue copy
    function automatic deque_result_t predict_deque_step(
        input logic [KIND_W-1:0] k,
        input logic signed [VALUE_W-1:0] v,
        input logic [POS_W-1:0] p
    );
        deque_result_t r;
        r.data   = DATA_ERR;
        r.status = ST_OK;
        case (k)
            K_PUSH_FRONT: begin
                if (model_fill >= DQ_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    model_head = (model_head + DQ_DEPTH - 1) % DQ_DEPTH;
                    model_ring[model_head] = v;
                    model_fill++;
                    r.data = v;
                end
            end
            K_POP_FRONT, K_READ_FIRST: begin
                if (model_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data = model_ring[model_head];
                    if (k == K_POP_FRONT) begin
                        model_head = (model_head + 1) % DQ_DEPTH;
                        model_fill--;
                    end
                end
            end
            K_POP_BACK, K_READ_LAST: begin
                if (model_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data = model_ring[(model_head + model_fill - 1) % DQ_DEPTH];
                    if (k == K_POP_BACK) model_fill--;
                end
            end
            K_READ_AT: begin
                if (model_fill == 0) begin
                    r.status = ST_EMPTY;
                end else if (int'(p) >= model_fill) begin
                    r.status = ST_RANGE;
                end else begin
                    r.data = model_ring[(model_head + int'(p)) % DQ_DEPTH];
                end
            end
            default: begin
                r.data = DATA_NONE;
            end
        endcase
        r.count = COUNT_W'(model_fill);
        if (model_fill > peak_fill) peak_fill = model_fill;
        return r;
    endfunction

    // one request transfer; entered and left at a falling edge
    task automatic send_request(
        input logic [KIND_W-1:0] k,
        input logic signed [VALUE_W-1:0] v,
        input logic [POS_W-1:0] p,
        input logic use_typed,
        input deque_result_t typed_result
    );
        deque_result_t predicted;
        while ($urandom_range(99) < source_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.kind     <= k;
        req_ch.value    <= v;
        req_ch.position <= p;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        predicted = predict_deque_step(k, v, p);
        pending_results.push_back(use_typed ? typed_result : predicted);
        n_requests++;
        @(negedge i_clk);
    endtask

    // hold off requests until every result is back
    task automatic wait_results_drained();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // bursts that lean towards filling, draining or a balanced mix
    task automatic run_random_items(input int n_items);
        int done;
        int burst;
        int push_pct;
        int r;
        logic [KIND_W-1:0]         k;
        logic signed [VALUE_W-1:0] v;
        logic [POS_W-1:0]          p;
        done = 0;
        while (done < n_items) begin
            case ($urandom_range(2))
                0:       push_pct = 80;
                1:       push_pct = 15;
                default: push_pct = 45;
            endcase
            burst = $urandom_range(24, 4);
            repeat (burst) begin
                r = $urandom_range(99);
                if ($urandom_range(7) == 0) begin
                    case ($urandom_range(3))
                        0:       v = VAL_MAX;
                        1:       v = VAL_MIN;
                        2:       v = DATA_ERR;
                        default: v = VAL_ZERO;
                    endcase
                end else begin
                    v = $urandom;
                end
                if (model_fill > 0 && $urandom_range(3) != 0)
                    p = POS_W'($urandom_range(model_fill - 1));
                else
                    p = POS_W'($urandom_range(15));
                if (r < 2) begin
                    k = $urandom_range(1) ? K_SPARE_6 : K_SPARE_7;
                end else if (r < 2 + push_pct * 98 / 100) begin
                    k = K_PUSH_FRONT;
                    done++;
                end else begin
                    case ($urandom_range(4))
                        0:       k = K_POP_FRONT;
                        1:       k = K_POP_BACK;
                        2:       k = K_READ_FIRST;
                        3:       k = K_READ_LAST;
                        default: k = K_READ_AT;
                    endcase
                    done++;
                end
                send_request(k, v, p, 1'b0, '0);
            end
        end
    endtask

    // result sink stalls at random
    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        deque_result_t want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            n_results++;
            status_seen[rsp_ch.status]++;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: data %0d status %0d count %0d",
                       rsp_ch.data, rsp_ch.status, rsp_ch.count);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.data !== want.data) begin
                    $error("data: expected %0d, got %0d", want.data, rsp_ch.data);
                    n_errors++;
                end
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    n_errors++;
                end
                if (rsp_ch.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb_double_ended_queue: done, errors");
            $finish;
        end
    end

    // reset, directed table, three idling patterns, wind-down
    initial begin
        dir_row_t                  row;
        logic signed [VALUE_W-1:0] v;
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.kind     = '0;
        req_ch.value    = '0;
        req_ch.position = '0;
        rsp_ch.ready    = 1'b0;
        source_idle_pct = 25;
        sink_idle_pct   = 84;
        model_head      = 0;
        model_fill      = 0;
        n_requests      = 0;
        n_results       = 0;
        n_errors        = 0;
        peak_fill       = 0;
        quiet_cycles    = 0;
        foreach (status_seen[i]) status_seen[i] = 0;

        repeat (RESET_LEN) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        for (int i = 0; i < N_DIR; i++) begin
            row = DIRECTED_ROWS[i];
            repeat (row.reps) begin
                v = (row.reps > 1) ? VALUE_W'($urandom) : row.value;
                send_request(row.kind, v, row.position, row.typed, row.result);
            end
        end
        run_random_items(PHASE_ITEMS);
        wait_results_drained();

        source_idle_pct = 84;
        sink_idle_pct   = 25;
        run_random_items(PHASE_ITEMS);
        wait_results_drained();

        source_idle_pct = 0;
        sink_idle_pct   = 0;
        run_random_items(PHASE_ITEMS);
        wait_results_drained();
        repeat (SETTLE_LEN) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            n_errors++;
        end
        $display("covered %0d requests and %0d results, queue depth peaked at %0d",
                 n_requests, n_results, peak_fill);
        $display("statuses seen: ok %0d, empty %0d, full %0d, out of range %0d",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
                 status_seen[ST_RANGE]);
        if (n_errors == 0) begin
            $display("tb_double_ended_queue: done, clean");
        end else begin
            $display("tb_double_ended_queue: done, errors");
        end
        $finish;
    end

endmodule : tb_double_ended_queue

[filelist.f]
rtl/dq_pkg.sv
rtl/dq_if.sv
rtl/dq_ram.sv
rtl/dq_ctrl.sv
rtl/dq_datapath.sv
rtl/double_ended_queue.sv
test/tb_double_ended_queue.sv
